### rtl/pctc_pkg.sv
// ----------------------------------------------------------------------------
// pctc_pkg
// Shared types, geometry constants and helpers for the page cache tag
// controller: cache geometry, command codes, request and result records.
// ----------------------------------------------------------------------------
package pctc_pkg;

    // Cache geometry (powers of two)
    localparam int WAYS        = 8;
    localparam int SETS        = 1024;
    localparam int PAGE_BYTES  = 4096;
    localparam int FLASH_PAGES = 1048576;
    localparam int ALIGN_BYTES = 64;

    localparam int ADDR_W  = 36;
    localparam int STAMP_W = 32;
    localparam int WAY_W   = $clog2(WAYS);
    localparam int SET_W   = $clog2(SETS);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int ALIGN_W = $clog2(ALIGN_BYTES);
    localparam int RANGE_W = $clog2(FLASH_PAGES) + OFF_W;
    localparam int TAG_W   = RANGE_W - OFF_W - SET_W;
    localparam int PAGE_W  = ADDR_W - OFF_W;
    localparam int HIGH_W  = ADDR_W - OFF_W - SET_W;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_HOST   = 2'd0,
        FUNC_VICTIM = 2'd1,
        FUNC_FILL   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Output command codes
    typedef enum logic [2:0] {
        CMD_DRAM_RD   = 3'd0,
        CMD_DRAM_WR   = 3'd1,
        CMD_FLASH_RD  = 3'd2,
        CMD_FLASH_WR  = 3'd3,
        CMD_WRITE_ACK = 3'd4,
        CMD_RANGE_ERR = 3'd5,
        CMD_NO_PEND   = 3'd6,
        CMD_BUSY      = 3'd7
    } cmd_t;

    // Per-set miss phase
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_VICTIM = 2'd1,
        PEND_FILL   = 2'd2,
        PEND_RSVD   = 2'd3
    } pend_t;

    // Request handed from front to back
    typedef struct packed {
        func_t              func;
        logic [ADDR_W-1:0]  addr;
        logic               is_write;
        logic [STAMP_W-1:0] now;
    } req_t;

    // One cache line's state
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               valid;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    // Open miss record for one set
    typedef struct packed {
        pend_t              pend;
        logic [WAY_W-1:0]   way;
        logic               is_write;
        logic [ADDR_W-1:0]  record;
    } miss_t;

    // One result item
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              last;
    } res_t;

    function automatic res_t mk_res(cmd_t cmd, logic [ADDR_W-1:0] addr,
                                    logic hit, logic last);
        res_t r;
        r.cmd  = cmd;
        r.addr = addr;
        r.hit  = hit;
        r.last = last;
        return r;
    endfunction

endpackage

### rtl/pctc_ram.sv
// ----------------------------------------------------------------------------
// pctc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/pctc_front.sv
// ----------------------------------------------------------------------------
// pctc_front
// Accept requests from the input stream, drop unused function codes and
// hold the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pctc_front
    import pctc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 q_valid,
    output req_t                 q_req,
    input  logic                 q_pop
);

    req_t       ent_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    req_t       in_req;
    logic       push;

    // Unpack the incoming request
    always_comb begin
        in_req.func     = func_t'(s_axis_tuser[1:0]);
        in_req.is_write = s_axis_tuser[2];
        in_req.addr     = s_axis_tdata[ADDR_W-1:0];
        in_req.now      = s_axis_tdata[ADDR_W +: STAMP_W];
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push    = s_axis_tvalid && s_axis_tready && (in_req.func != FUNC_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = ent_reg[rptr_reg];

    // Advance queue pointers
    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ q_pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold request payload
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= in_req;
        end
    end

endmodule

### rtl/pctc_back.sv
// ----------------------------------------------------------------------------
// pctc_back
// Carry out queued requests: tag lookup, LRU victim scan, miss tracking and
// line state update, then drive up to two result items on the output stream.
// ----------------------------------------------------------------------------
module pctc_back
    import pctc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  req_t                 q_req,
    output logic                 q_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_MISS,
        S_OUT0,
        S_OUT1
    } state_t;

    state_t             state_reg, state_next;
    logic [SET_W-1:0]   clr_reg, clr_next;
    req_t               cur_reg, cur_next;
    res_t               res0_reg, res0_next;
    res_t               res1_reg, res1_next;
    logic               two_reg, two_next;
    logic [WAY_W-1:0]   idx_reg, idx_next;
    logic [WAY_W-1:0]   vict_reg, vict_next;
    logic [STAMP_W-1:0] min_reg, min_next;

    logic               mem_we, mem_re;
    logic [SET_W-1:0]   mem_waddr, mem_raddr;
    row_t               row_rdata, row_wdata;
    miss_t              miss_rdata, miss_wdata;

    logic [SET_W-1:0]   cur_set;
    logic [TAG_W-1:0]   cur_tag;
    logic               hit_any;
    logic [WAY_W-1:0]   hit_way;
    logic [ADDR_W-1:0]  off_al;
    logic [ADDR_W-1:0]  flash_page;

    pctc_ram #(.WIDTH($bits(row_t)), .DEPTH(SETS)) u_row_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (row_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (row_rdata)
    );

    pctc_ram #(.WIDTH($bits(miss_t)), .DEPTH(SETS)) u_miss_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (miss_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (miss_rdata)
    );

    // Address fields of the current request
    assign cur_set    = cur_reg.addr[OFF_W +: SET_W];
    assign cur_tag    = cur_reg.addr[OFF_W+SET_W +: TAG_W];
    assign off_al     = ADDR_W'({cur_reg.addr[OFF_W-1:ALIGN_W], ALIGN_W'(0)});
    assign flash_page = {cur_reg.addr[ADDR_W-1:OFF_W], OFF_W'(0)};

    // Compare all ways, take the lowest matching one
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row_rdata[w].valid && row_rdata[w].tag == cur_tag) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cur_next   = cur_reg;
        res0_next  = res0_reg;
        res1_next  = res1_reg;
        two_next   = two_reg;
        idx_next   = idx_reg;
        vict_next  = vict_reg;
        min_next   = min_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = cur_set;
        mem_raddr  = q_req.addr[OFF_W +: SET_W];
        row_wdata  = row_rdata;
        miss_wdata = miss_rdata;

        case (state_reg)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = clr_reg;
                row_wdata  = '0;
                miss_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == SET_W'(SETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    mem_re     = 1'b1;
                    cur_next   = q_req;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                two_next   = 1'b0;
                state_next = S_OUT0;
                case (cur_reg.func)
                    FUNC_HOST: begin
                        if (miss_rdata.pend != PEND_NONE) begin
                            res0_next = mk_res(CMD_BUSY, cur_reg.addr, 1'b0, 1'b1);
                        end else if (|cur_reg.addr[ADDR_W-1:RANGE_W]) begin
                            res0_next = mk_res(CMD_RANGE_ERR, cur_reg.addr, 1'b0, 1'b1);
                        end else if (hit_any) begin
                            mem_we = 1'b1;
                            row_wdata[hit_way].stamp = cur_reg.now;
                            if (cur_reg.is_write) begin
                                row_wdata[hit_way].dirty = 1'b1;
                                two_next  = 1'b1;
                                res0_next = mk_res(CMD_DRAM_WR,
                                    ADDR_W'({hit_way, cur_set, OFF_W'(0)}) | off_al,
                                    1'b1, 1'b0);
                                res1_next = mk_res(CMD_WRITE_ACK, cur_reg.addr, 1'b1, 1'b1);
                            end else begin
                                res0_next = mk_res(CMD_DRAM_RD,
                                    ADDR_W'({hit_way, cur_set, OFF_W'(0)}) | off_al,
                                    1'b1, 1'b1);
                            end
                        end else begin
                            // Start LRU scan at the first way
                            min_next   = row_rdata[0].stamp;
                            vict_next  = '0;
                            idx_next   = WAY_W'(1);
                            state_next = (WAYS > 1) ? S_SCAN : S_MISS;
                        end
                    end
                    FUNC_VICTIM: begin
                        if (miss_rdata.pend != PEND_VICTIM ||
                            cur_reg.addr[ADDR_W-1:OFF_W+SET_W] != HIGH_W'(miss_rdata.way)) begin
                            res0_next = mk_res(CMD_NO_PEND, cur_reg.addr, 1'b0, 1'b1);
                        end else begin
                            mem_we          = 1'b1;
                            miss_wdata.pend = PEND_FILL;
                            two_next        = 1'b1;
                            res0_next = mk_res(CMD_FLASH_WR,
                                ADDR_W'({row_rdata[miss_rdata.way].tag, cur_set, OFF_W'(0)}),
                                1'b0, 1'b0);
                            res1_next = mk_res(CMD_FLASH_RD,
                                {miss_rdata.record[ADDR_W-1:OFF_W], OFF_W'(0)}, 1'b0, 1'b1);
                        end
                    end
                    FUNC_FILL: begin
                        if (miss_rdata.pend != PEND_FILL ||
                            miss_rdata.record[ADDR_W-1:OFF_W] != cur_reg.addr[ADDR_W-1:OFF_W]) begin
                            res0_next = mk_res(CMD_NO_PEND, cur_reg.addr, 1'b0, 1'b1);
                        end else begin
                            // Install the line and close the miss
                            mem_we = 1'b1;
                            row_wdata[miss_rdata.way].tag   = cur_tag;
                            row_wdata[miss_rdata.way].valid = 1'b1;
                            row_wdata[miss_rdata.way].stamp = cur_reg.now;
                            row_wdata[miss_rdata.way].dirty = miss_rdata.is_write;
                            miss_wdata.pend = PEND_NONE;
                            if (miss_rdata.is_write) begin
                                two_next  = 1'b1;
                                res0_next = mk_res(CMD_DRAM_WR,
                                    ADDR_W'({miss_rdata.way, cur_set,
                                             miss_rdata.record[OFF_W-1:ALIGN_W],
                                             ALIGN_W'(0)}), 1'b0, 1'b0);
                                res1_next = mk_res(CMD_WRITE_ACK, miss_rdata.record,
                                                   1'b0, 1'b1);
                            end else begin
                                res0_next = mk_res(CMD_DRAM_RD,
                                    ADDR_W'({miss_rdata.way, cur_set,
                                             miss_rdata.record[OFF_W-1:ALIGN_W],
                                             ALIGN_W'(0)}), 1'b0, 1'b1);
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                // Keep the oldest stamp, first way on ties
                if (row_rdata[idx_reg].stamp < min_reg) begin
                    min_next  = row_rdata[idx_reg].stamp;
                    vict_next = idx_reg;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == WAY_W'(WAYS - 1)) begin
                    state_next = S_MISS;
                end
            end
            S_MISS: begin
                mem_we              = 1'b1;
                miss_wdata.way      = vict_reg;
                miss_wdata.is_write = cur_reg.is_write;
                miss_wdata.record   = cur_reg.addr;
                two_next            = 1'b0;
                state_next          = S_OUT0;
                if (row_rdata[vict_reg].dirty) begin
                    miss_wdata.pend = PEND_VICTIM;
                    res0_next = mk_res(CMD_DRAM_RD,
                        ADDR_W'({vict_reg, cur_set, OFF_W'(0)}), 1'b0, 1'b1);
                end else begin
                    miss_wdata.pend = PEND_FILL;
                    res0_next = mk_res(CMD_FLASH_RD, flash_page, 1'b0, 1'b1);
                end
            end
            S_OUT0: begin
                if (m_axis_tready) begin
                    state_next = two_reg ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1: begin
                if (m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
        cur_reg  <= cur_next;
        res0_reg <= res0_next;
        res1_reg <= res1_next;
        two_reg  <= two_next;
        idx_reg  <= idx_next;
        vict_reg <= vict_next;
        min_reg  <= min_next;
    end

    // Drive the result stream
    res_t res_out;
    assign res_out       = (state_reg == S_OUT1) ? res1_reg : res0_reg;
    assign m_axis_tvalid = (state_reg == S_OUT0) || (state_reg == S_OUT1);
    assign m_axis_tdata  = M_TDATA_W'(res_out.addr);
    assign m_axis_tuser  = {res_out.hit, res_out.cmd};
    assign m_axis_tlast  = res_out.last;

endmodule

### rtl/page_cache_tag_controller.sv
// ----------------------------------------------------------------------------
// page_cache_tag_controller
// Set-associative write-back DRAM page cache tag controller in front of flash.
// ----------------------------------------------------------------------------
// After reset the controller sweeps its tag and miss memories, one set per
// cycle; up to two requests are queued during that pass but none is
// carried out before it ends. For host hits and completions the set's row
// is first read from the tag memory, then compared and updated, and then
// each result is driven on the output, which may stall. A host miss adds
// an LRU stamp scan over the ways after the first and a step to record
// the miss. Up to two requests wait in the input queue while a result
// is pending.
module page_cache_tag_controller
    import pctc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // addr[35:0], now[67:36]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // func[1:0], is_write[2]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // cmd_addr[35:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // cmd[2:0], hit[3]
    output logic                 m_axis_tlast
);

    logic q_valid;
    logic q_pop;
    req_t q_req;

    pctc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop)
    );

    pctc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### rtl/pctc_checker.sv
// ----------------------------------------------------------------------------
// pctc_checker
// Port-level checks on the result stream of the page cache tag controller.
// ----------------------------------------------------------------------------
module pctc_checker
    import pctc_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Write ack closes its request
    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2:0] == CMD_WRITE_ACK |-> m_axis_tlast)
        else $error("write ack not last");

    // Flash write is always followed by the fill read
    a_fwr_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2:0] == CMD_FLASH_WR |-> !m_axis_tlast)
        else $error("flash write marked last");

    // Hit only on DRAM access or ack
    a_hit_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tuser[2:0] == CMD_DRAM_RD || m_axis_tuser[2:0] == CMD_DRAM_WR ||
            m_axis_tuser[2:0] == CMD_WRITE_ACK)
        else $error("hit on wrong command");

    // Error answers stand alone
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser[2:0] == CMD_BUSY ||
            m_axis_tuser[2:0] == CMD_RANGE_ERR || m_axis_tuser[2:0] == CMD_NO_PEND)
            |-> m_axis_tlast && !m_axis_tuser[3])
        else $error("error answer not single");

endmodule

bind page_cache_tag_controller pctc_checker u_pctc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### sim/tb_page_cache_tag_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_cache_tag_controller
// Self-checking testbench for the page cache tag controller. A behavioral
// tag store, LRU scan and per-set miss tracker predict the commands for each
// accepted request. Directed tests cover hits, misses, dirty evictions and
// the error answers. A random phase then mixes well-formed miss sequences
// with noise. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_page_cache_tag_controller;
    import pctc_pkg::*;

    localparam int LINE_CNT   = WAYS * SETS;
    localparam int RAND_ITEMS = 1400;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // addr[35:0], now[67:36]
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;  // func[1:0], is_write[2]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;       // cmd_addr[35:0]
    logic [M_TUSER_W-1:0] m_axis_tuser;       // cmd[2:0], hit[3]
    logic                 m_axis_tlast;

    page_cache_tag_controller dut (.*);

    // Shadow tag store and miss tracker
    logic [TAG_W-1:0]   shadow_tag   [LINE_CNT];
    bit                 shadow_valid [LINE_CNT];
    bit                 shadow_dirty [LINE_CNT];
    logic [STAMP_W-1:0] shadow_stamp [LINE_CNT];
    pend_t              open_phase   [SETS];
    logic [ADDR_W-1:0]  open_addr    [SETS];
    logic [WAY_W-1:0]   open_way     [SETS];
    bit                 open_write   [SETS];
    int                 open_sets[$];

    res_t               pending_cmds[$];
    int                 errors;
    int                 requests_sent;
    int                 cmds_checked;
    int                 hits_seen;
    int                 evictions_seen;
    bit                 no_idle;
    bit                 hold_ready;
    logic [STAMP_W-1:0] cycle_stamp;

    // Clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_stamp <= cycle_stamp + 32'd1;

    // Random output stalls: mostly short, now and then a long one
    int stall_left;
    always @(posedge aclk) begin
        if (hold_ready || no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 19))
                0:       stall_left <= $urandom_range(10, 40);
                1, 2, 3: stall_left <= $urandom_range(0, 3);
                default: stall_left <= 0;
            endcase
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic void push_cmd(cmd_t c, logic [ADDR_W-1:0] a, bit h, bit l);
        res_t r;
        r.cmd  = c;
        r.addr = a;
        r.hit  = h;
        r.last = l;
        pending_cmds = {pending_cmds, r};
    endfunction

    // Update the shadow state for one request and queue its commands
    function automatic void predict_request(func_t fn, logic [ADDR_W-1:0] addr,
                                            bit wr, logic [STAMP_W-1:0] now);
        logic [ADDR_W-1:0]  al;
        logic [PAGE_W-1:0]  page;
        logic [SET_W-1:0]   set;
        logic [HIGH_W-1:0]  high;
        logic [WAY_W-1:0]   victim;
        logic [STAMP_W-1:0] oldest;
        int                 li;
        al   = {addr[ADDR_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
        page = (fn == FUNC_HOST) ? al[ADDR_W-1:OFF_W] : addr[ADDR_W-1:OFF_W];
        set  = page[SET_W-1:0];
        high = page[PAGE_W-1:SET_W];
        case (fn)
            FUNC_HOST: begin
                if (open_phase[set] != PEND_NONE) begin
                    push_cmd(CMD_BUSY, addr, 0, 1);
                    return;
                end
                if (al[ADDR_W-1:RANGE_W] != 0) begin
                    push_cmd(CMD_RANGE_ERR, addr, 0, 1);
                    return;
                end
                for (int w = 0; w < WAYS; w++) begin
                    li = w * SETS + set;
                    if (shadow_valid[li] && HIGH_W'(shadow_tag[li]) == high) begin
                        shadow_stamp[li] = now;
                        hits_seen++;
                        if (wr) begin
                            shadow_dirty[li] = 1;
                            push_cmd(CMD_DRAM_WR, ADDR_W'(li * PAGE_BYTES) + al[OFF_W-1:0],
                                     1, 0);
                            push_cmd(CMD_WRITE_ACK, addr, 1, 1);
                        end else begin
                            push_cmd(CMD_DRAM_RD, ADDR_W'(li * PAGE_BYTES) + al[OFF_W-1:0],
                                     1, 1);
                        end
                        return;
                    end
                end
                // LRU: smallest stamp, lowest way on ties
                victim = 0;
                oldest = shadow_stamp[set];
                for (int w = 1; w < WAYS; w++) begin
                    if (shadow_stamp[w * SETS + set] < oldest) begin
                        victim = WAY_W'(w);
                        oldest = shadow_stamp[w * SETS + set];
                    end
                end
                open_addr[set]  = addr;
                open_way[set]   = victim;
                open_write[set] = wr;
                open_sets = {open_sets, int'(set)};
                if (shadow_dirty[victim * SETS + set]) begin
                    open_phase[set] = PEND_VICTIM;
                    evictions_seen++;
                    push_cmd(CMD_DRAM_RD, ADDR_W'((victim * SETS + set) * PAGE_BYTES), 0, 1);
                end else begin
                    open_phase[set] = PEND_FILL;
                    push_cmd(CMD_FLASH_RD, {page, {OFF_W{1'b0}}}, 0, 1);
                end
            end
            FUNC_VICTIM: begin
                if (open_phase[set] != PEND_VICTIM || high != HIGH_W'(open_way[set])) begin
                    push_cmd(CMD_NO_PEND, addr, 0, 1);
                    return;
                end
                li = open_way[set] * SETS + set;
                open_phase[set] = PEND_FILL;
                push_cmd(CMD_FLASH_WR, ADDR_W'({shadow_tag[li], set, {OFF_W{1'b0}}}), 0, 0);
                push_cmd(CMD_FLASH_RD, {open_addr[set][ADDR_W-1:OFF_W], {OFF_W{1'b0}}}, 0, 1);
            end
            FUNC_FILL: begin
                if (open_phase[set] != PEND_FILL || open_addr[set][ADDR_W-1:OFF_W] != page) begin
                    push_cmd(CMD_NO_PEND, addr, 0, 1);
                    return;
                end
                li = open_way[set] * SETS + set;
                shadow_tag[li]   = high[TAG_W-1:0];
                shadow_valid[li] = 1;
                shadow_stamp[li] = now;
                shadow_dirty[li] = open_write[set];
                open_phase[set]  = PEND_NONE;
                foreach (open_sets[i])
                    if (open_sets[i] == set) begin
                        open_sets.delete(i);
                        break;
                    end
                al = {open_addr[set][ADDR_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
                if (open_write[set]) begin
                    push_cmd(CMD_DRAM_WR, ADDR_W'(li * PAGE_BYTES) + al[OFF_W-1:0], 0, 0);
                    push_cmd(CMD_WRITE_ACK, open_addr[set], 0, 1);
                end else begin
                    push_cmd(CMD_DRAM_RD, ADDR_W'(li * PAGE_BYTES) + al[OFF_W-1:0], 0, 1);
                end
            end
            default: ;
        endcase
    endfunction

    // Check each accepted command against the oldest expectation
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            cmds_checked++;
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected command cmd=%0d addr=%h", $time,
                         m_axis_tuser[2:0], m_axis_tdata[ADDR_W-1:0]);
            end else begin
                want = pending_cmds[0];
                pending_cmds.delete(0);
                if (m_axis_tuser[2:0] != want.cmd) begin
                    errors++;
                    $display("%0t: cmd expected %0d actual %0d", $time, want.cmd,
                             m_axis_tuser[2:0]);
                end
                if (m_axis_tdata[ADDR_W-1:0] != want.addr) begin
                    errors++;
                    $display("%0t: cmd_addr expected %h actual %h", $time, want.addr,
                             m_axis_tdata[ADDR_W-1:0]);
                end
                if (m_axis_tuser[3] != want.hit) begin
                    errors++;
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit,
                             m_axis_tuser[3]);
                end
                if (m_axis_tlast != want.last) begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last,
                             m_axis_tlast);
                end
            end
        end
    end

    // Send one request, predict it on acceptance, then sometimes idle a while
    task automatic send_request(func_t fn, logic [ADDR_W-1:0] addr, bit wr,
                                logic [STAMP_W-1:0] now);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, now, addr};
        s_axis_tuser  <= {wr, fn};
        do @(posedge aclk); while (!s_axis_tready);
        predict_request(fn, addr, wr, now);
        requests_sent++;
        case ($urandom_range(0, 19))
            0:          gap = $urandom_range(10, 40);
            1, 2, 3, 4: gap = $urandom_range(1, 3);
            default:    gap = 0;
        endcase
        if (no_idle) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] host_addr(int set, int tag);
        return ADDR_W'({tag[TAG_W-1:0], set[SET_W-1:0], 12'($urandom)});
    endfunction

    // Answer the open miss of a set with the completion it waits for
    task automatic complete_miss(int set);
        if (open_phase[set] == PEND_VICTIM)
            send_request(FUNC_VICTIM,
                         ADDR_W'({open_way[set], set[SET_W-1:0], 12'($urandom)}),
                         1'($urandom_range(0, 1)), $urandom);
        else if (open_phase[set] == PEND_FILL)
            send_request(FUNC_FILL, {open_addr[set][ADDR_W-1:OFF_W], 12'($urandom)},
                         1'($urandom_range(0, 1)), cycle_stamp);
    endtask

    // Stop sending and wait until every expected command has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // Clean miss, fill, read hit and write hit at the address extremes
    task automatic test_hit_miss();
        send_request(FUNC_HOST, 36'h0, 0, 32'h0);
        complete_miss(0);
        send_request(FUNC_HOST, 36'h3F, 0, 32'hFFFF_FFFF);
        send_request(FUNC_HOST, 36'h0_FFFF_FFFF, 1, 32'h0);
        while (open_phase[SETS-1] != PEND_NONE) complete_miss(SETS - 1);
        send_request(FUNC_HOST, 36'h0_FFFF_FFC0, 1, 32'h1234_5678);
        send_request(FUNC_HOST, 36'h0_FFFF_FFFF, 0, 32'h8000_0000);
        drain();
    endtask

    // Range error, busy before range, unmatched completions, unused func
    task automatic test_error_answers();
        send_request(FUNC_HOST, 36'hF_FFFF_FFFF, 1, 32'hFFFF_FFFF);
        send_request(FUNC_HOST, 36'h1_0000_0000, 0, 32'h0);
        send_request(FUNC_HOST, host_addr(7, 3), 0, cycle_stamp);
        send_request(FUNC_HOST, 36'hF_0000_7000, 0, cycle_stamp);
        send_request(FUNC_HOST, host_addr(7, 3), 1, cycle_stamp);
        send_request(FUNC_VICTIM, 36'h0_0000_7000, 0, 32'h0);
        send_request(FUNC_FILL, 36'hF_FFFF_FFFF, 0, 32'h0);
        complete_miss(7);
        send_request(FUNC_FILL, host_addr(7, 3), 0, 32'h0);
        send_request(FUNC_NONE, 36'hF_FFFF_FFFF, 1, 32'hFFFF_FFFF);
        drain();
    endtask

    // Fill all ways of one set with writes, then force dirty evictions
    task automatic test_eviction();
        for (int t = 0; t < WAYS + 2; t++) begin
            send_request(FUNC_HOST, host_addr(5, t + 1), 1, cycle_stamp);
            while (open_phase[5] != PEND_NONE) complete_miss(5);
        end
        drain();
    endtask

    // Random mix: hot sets, more tags than ways, completions and noise
    task automatic test_random();
        int set, tag, pick;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            no_idle = (n / 200) % 3 == 2;
            pick = $urandom_range(0, 99);
            if (pick < 40 && open_sets.size() != 0) begin
                complete_miss(open_sets[$urandom_range(0, open_sets.size() - 1)]);
            end else if (pick < 88) begin
                set = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) * 171
                                                 : $urandom_range(0, SETS - 1);
                tag = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 11)
                                                 : $urandom_range(0, 1023);
                send_request(FUNC_HOST, host_addr(set, tag), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 3) == 0 ? $urandom : cycle_stamp);
            end else if (pick < 91) begin
                send_request(FUNC_HOST, ADDR_W'({$urandom, $urandom} >> 28),
                             1'($urandom_range(0, 1)), $urandom);
            end else if (pick < 96) begin
                send_request(func_t'($urandom_range(1, 2)),
                             ADDR_W'({$urandom, $urandom} >> 28),
                             1'($urandom_range(0, 1)), $urandom);
            end else begin
                send_request(FUNC_NONE, ADDR_W'({$urandom, $urandom} >> 28),
                             1'($urandom_range(0, 1)), $urandom);
                n--;
            end
        end
        no_idle = 0;
        // close what is still open so the run ends idle
        while (open_sets.size() != 0) complete_miss(open_sets[0]);
        s_axis_tvalid <= 1'b0;
        drain();
    endtask

    initial begin
        for (int i = 0; i < LINE_CNT; i++) begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 0;
            shadow_dirty[i] = 0;
            shadow_stamp[i] = '0;
        end
        for (int i = 0; i < SETS; i++) begin
            open_phase[i] = PEND_NONE;
            open_addr[i]  = '0;
            open_way[i]   = '0;
            open_write[i] = 0;
        end
        errors = 0; requests_sent = 0; cmds_checked = 0;
        hits_seen = 0; evictions_seen = 0;
        no_idle = 0; hold_ready = 0; stall_left = 0; cycle_stamp = 32'd100;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_hit_miss();
        test_error_answers();
        test_eviction();
        test_random();

        $display("Sent %0d requests, checked %0d commands", requests_sent, cmds_checked);
        $display("Saw %0d hits and %0d dirty evictions", hits_seen, evictions_seen);
        if (errors == 0 && pending_cmds.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4ms;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
rtl/pctc_pkg.sv
rtl/pctc_ram.sv
rtl/pctc_front.sv
rtl/pctc_back.sv
rtl/page_cache_tag_controller.sv
rtl/pctc_checker.sv
sim/tb_page_cache_tag_controller.sv
